>>> src/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
package sli_pkg;

  // list capacity, 2 .. 31 (count_o is CountW = 5 bits wide)
  localparam int unsigned Depth  = 16;
  localparam int unsigned FillW  = $clog2(Depth + 1);
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatusW = 2;

  // opcodes
  localparam logic OpInsert = 1'b0;
  localparam logic OpDelete = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StatusDone     = 2'd0;
  localparam logic [StatusW-1:0] StatusFull     = 2'd1;
  localparam logic [StatusW-1:0] StatusNotFound = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StUpd,
    StResp
  } sli_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the incoming transaction
    logic compare;  // register per-cell compare results
    logic update;   // shift the cells and form the result
  } sli_cmd_t;

endpackage

>>> src/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer: accept, compare, update, respond.
// ----------------------------------------------------------------------------
module sli_ctrl import sli_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output logic     done_o,
  output sli_cmd_t cmd_o
);

  sli_state_e state_q, state_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    busy_o = state_q inside {StCmp, StUpd};
    accept = start_i && !busy_o;
    done_o = (state_q == StResp);
    cmd_o.load    = accept;
    cmd_o.compare = (state_q == StCmp);
    cmd_o.update  = (state_q == StUpd);
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StCmp;
      end
      StCmp:  state_d = StUpd;
      StUpd:  state_d = StResp;
      StResp: begin
        state_d = accept ? StCmp : StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

>>> src/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath
// Row of compare-and-shift cells holding the list, plus result registers.
// ----------------------------------------------------------------------------
module sli_datapath import sli_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sli_cmd_t                 cmd_i,
  input  logic                     opcode_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic [StatusW-1:0]       status_o,
  output logic [CountW-1:0]        count_o,
  output logic signed [ValueW-1:0] smallest_o
);

  logic signed [ValueW-1:0] entry_q [Depth];
  logic signed [ValueW-1:0] entry_d [Depth];
  logic signed [ValueW-1:0] ins_e   [Depth];
  logic signed [ValueW-1:0] del_e   [Depth];
  logic [FillW-1:0]         fill_q, fill_d;
  logic                     op_q;
  logic signed [ValueW-1:0] value_q;
  logic [Depth-1:0]         lt_q, lt_now, eq_now, valid, lt_prev_now, lt_prev_q;
  logic [Depth-1:0]         first_ge;
  logic                     found_q, found_now;
  logic                     full;
  logic [StatusW-1:0]       status_q, status_d;
  logic [CountW-1:0]        count_q;
  logic signed [ValueW-1:0] smallest_q, smallest_d;
  logic [FillW+CountW-1:0]  fill_ext;

  // compare stage: every cell checks itself against the value
  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      valid[j]  = fill_q > FillW'(j);
      lt_now[j] = valid[j] && (entry_q[j] < value_q);
      eq_now[j] = valid[j] && (entry_q[j] == value_q);
    end
    lt_prev_now = {lt_now[Depth-2:0], 1'b1};
    // list is sorted, so the first cell not below the value is the only candidate
    first_ge  = valid & ~lt_now & lt_prev_now;
    found_now = |(first_ge & eq_now);
  end

  // update stage: shifted images of the row
  always_comb begin
    lt_prev_q = {lt_q[Depth-2:0], 1'b1};
    for (int j = 0; j < Depth; j++) begin
      if (lt_q[j]) begin
        ins_e[j] = entry_q[j];
      end else if (lt_prev_q[j] || j == 0) begin
        ins_e[j] = value_q;
      end else begin
        ins_e[j] = entry_q[(j == 0) ? 0 : j - 1];
      end
      if (lt_q[j] || j == Depth - 1) begin
        del_e[j] = entry_q[j];
      end else begin
        del_e[j] = entry_q[(j == Depth - 1) ? j : j + 1];
      end
    end
  end

  always_comb begin
    full     = (fill_q == FillW'(Depth));
    entry_d  = entry_q;
    fill_d   = fill_q;
    status_d = StatusDone;
    if (op_q == OpInsert) begin
      if (full) begin
        status_d = StatusFull;
      end else begin
        entry_d = ins_e;
        fill_d  = fill_q + FillW'(1);
      end
    end else begin
      if (found_q) begin
        entry_d = del_e;
        fill_d  = fill_q - FillW'(1);
      end else begin
        status_d = StatusNotFound;
      end
    end
    smallest_d = (fill_d != '0) ? entry_d[0] : '0;
    fill_ext   = {{CountW{1'b0}}, fill_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.update) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      value_q <= value_i;
    end
    if (cmd_i.compare) begin
      lt_q    <= lt_now;
      found_q <= found_now;
    end
    if (cmd_i.update) begin
      entry_q    <= entry_d;
      status_q   <= status_d;
      count_q    <= fill_ext[CountW-1:0];
      smallest_q <= smallest_d;
    end
  end

  assign status_o   = status_q;
  assign count_o    = count_q;
  assign smallest_o = smallest_q;

endmodule

>>> src/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed 32-bit values with insert and delete.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: drive opcode_i/value_i and raise start; the transaction
//   is taken on a rising edge where start is high and busy is low.
//   opcode 0 inserts value before the first entry not less than it,
//   opcode 1 removes the first entry equal to value.
//   Result channel: done_o is high for one cycle with status_o, count_o
//   (entries after the transaction) and smallest_o (zero when empty).
//   Status: done, full (insert dropped) or not found (list unchanged).
// Timing
//   After the accept edge the sequencer steps through the compare state,
//   the update state and the result state, in which done_o is high. busy
//   is low in the result cycle, so a new transaction may be accepted there;
//   none is taken while one is in compare or update.
// Reset
//   rst_ni clears the fill count and the sequencer; cell contents are not
//   cleared, unused cells never reach a result. The receiver cannot stall: the
//   result is there for its one cycle only.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete import sli_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     done_o,
  output logic [StatusW-1:0]       status_o,
  output logic [CountW-1:0]        count_o,
  output logic signed [ValueW-1:0] smallest_o
);

  sli_cmd_t cmd;

  // sequencer: owns the handshake and steps the datapath
  sli_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // cell row and result registers
  sli_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .count_o    (count_o),
    .smallest_o (smallest_o)
  );

endmodule

>>> src/sli_checker.sv
// ----------------------------------------------------------------------------
// sli_checker
// Port-level checks of the sorted list block, bound to the top level.
// ----------------------------------------------------------------------------
module sli_checker import sli_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [StatusW-1:0] status_o
);

  // accepted transaction: busy through compare and update, then its result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy ##1 busy ##1 done_o)
    else $error("result not delivered three cycles after acceptance");

  // no result strobe without a transaction in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == StatusDone || status_o == StatusFull ||
                status_o == StatusNotFound))
    else $error("undefined status code");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .status_o (status_o)
);

>>> sim/tb_sorted_list_insert_delete.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete
// Self-checking bench for the sorted list insert/delete block.
// ----------------------------------------------------------------------------
// A queue of pending transactions is filled at time zero. It holds a directed
// opening, then about five hundred random transactions. A clocked driver
// presents them on the start/busy command port, with random gaps and with
// gap-free bursts. At every accept edge a shadow copy of the list predicts
// the one result that the transaction owes. A clocked monitor takes every
// done_o strobe and compares it, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete;
  import sli_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumRandom  = 500;
  localparam int unsigned PoolSize   = 8;

  // one command transaction as the driver sees it
  typedef struct {
    logic                     op;
    logic signed [ValueW-1:0] val;
    bit                       drain;  // hold off until every result is back
    int unsigned              gap;    // idle cycles ahead of this transaction
  } list_txn_t;

  // one result transaction
  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] smallest;
  } list_result_t;

  logic                     clk_i      = 1'b0;
  logic                     rst_ni     = 1'b0;
  logic                     start      = 1'b0;
  logic                     opcode_i   = OpInsert;
  logic signed [ValueW-1:0] value_i    = '0;
  logic                     busy;
  logic                     done_o;
  logic [StatusW-1:0]       status_o;
  logic [CountW-1:0]        count_o;
  logic signed [ValueW-1:0] smallest_o;

  list_txn_t                pending_q[$];
  logic signed [ValueW-1:0] shadow_list[$];     // predicted list contents, ascending
  list_result_t             expected_by_seq[int];
  int unsigned              issued_cnt = 0;     // transactions accepted
  int unsigned              seen_cnt   = 0;     // results matched to a prediction
  int unsigned              gap_left   = 0;
  int unsigned              cycle_cnt  = 0;
  int unsigned              errors     = 0;

  sorted_list_insert_delete i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .count_o    (count_o),
    .smallest_o (smallest_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: applies one transaction to the shadow list.
  // Insert goes before the first entry not less than the value; a full list
  // drops it. Delete removes the first equal entry, else reports not found.
  // --------------------------------------------------------------------------
  function automatic list_result_t list_apply(logic op, logic signed [ValueW-1:0] v);
    list_result_t r;
    int           pos;
    pos = 0;
    if (op == OpInsert) begin
      if (shadow_list.size() >= Depth) begin
        r.status = StatusFull;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] < v) pos++;
        shadow_list.insert(pos, v);
        r.status = StatusDone;
      end
    end else begin
      while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
      if (pos >= shadow_list.size()) begin
        r.status = StatusNotFound;
      end else begin
        shadow_list.delete(pos);
        r.status = StatusDone;
      end
    end
    r.count    = CountW'(shadow_list.size());
    r.smallest = (shadow_list.size() != 0) ? shadow_list[0] : '0;
    return r;
  endfunction

  task automatic push_txn(logic op, logic signed [ValueW-1:0] v, bit drain, int unsigned gap);
    list_txn_t t;
    t.op    = op;
    t.val   = v;
    t.drain = drain;
    t.gap   = gap;
    pending_q.push_back(t);
  endtask

  // --------------------------------------------------------------------------
  // Driver. Reads start/busy as they stood before the edge; start gets one
  // nonblocking assignment per edge at most, so a held start never glitches.
  // The counters move by nonblocking assignment so that driver and monitor
  // both see the pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    logic        took;
    int          outstanding;
    list_txn_t   nxt;
    if (rst_ni) begin
      took = start && !busy;
      if (took) begin
        expected_by_seq[issued_cnt] = list_apply(opcode_i, value_i);
        issued_cnt <= issued_cnt + 1;
      end
      // free to present something new unless a transaction is still waiting
      if (!start || took) begin
        outstanding = int'(issued_cnt) + int'(took) - int'(seen_cnt) - int'(done_o);
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_q.size() != 0 && !(pending_q[0].drain && outstanding != 0)) begin
          nxt      = pending_q.pop_front();
          start    <= 1'b1;
          opcode_i <= nxt.op;
          value_i  <= nxt.val;
          gap_left <= (pending_q.size() != 0) ? pending_q[0].gap : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: a result is there for one cycle and cannot be held off.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    list_result_t exp_r;
    if (rst_ni && done_o) begin
      if (seen_cnt >= issued_cnt) begin
        $display("%0t: result with no transaction outstanding: status %0d count %0d smallest %0d",
                 $time, status_o, count_o, smallest_o);
        errors++;
      end else begin
        exp_r = expected_by_seq[seen_cnt];
        expected_by_seq.delete(seen_cnt);
        if (status_o !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, status_o);
          errors++;
        end
        if (count_o !== exp_r.count) begin
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, exp_r.count, count_o);
          errors++;
        end
        if (smallest_o !== exp_r.smallest) begin
          $display("%0t: smallest mismatch: expected %0d, actual %0d",
                   $time, exp_r.smallest, smallest_o);
          errors++;
        end
        seen_cnt <= seen_cnt + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic signed [ValueW-1:0] pool[PoolSize];
    logic signed [ValueW-1:0] v;
    int unsigned              insert_pct;
    bit                       burst;

    // directed: empty list, extremes, duplicates, fill to full, then drain
    push_txn(OpDelete, 32'sd5, 1'b0, 0);              // delete on an empty list
    push_txn(OpInsert, 32'sh7fffffff, 1'b0, 0);
    push_txn(OpInsert, 32'sh80000000, 1'b0, 0);       // new smallest
    push_txn(OpInsert, 32'sd0, 1'b0, $urandom_range(0, 9));
    push_txn(OpInsert, -32'sd1, 1'b0, 0);
    push_txn(OpInsert, 32'sd0, 1'b0, 0);              // duplicate
    push_txn(OpDelete, 32'sh80000000, 1'b0, 0);       // smallest removed
    push_txn(OpDelete, 32'sd12345, 1'b0, 0);          // no match
    for (int i = 0; i < 12; i++)
      push_txn(OpInsert, $urandom, 1'b0, 0);
    push_txn(OpInsert, 32'sd1, 1'b0, 0);              // list full here: dropped
    push_txn(OpDelete, 32'sh7fffffff, 1'b1, 3);       // wait for all results first
    push_txn(OpDelete, -32'sd1, 1'b0, 0);
    push_txn(OpDelete, 32'sd0, 1'b0, 0);

    pool[0] = 32'sh7fffffff;
    pool[1] = 32'sh80000000;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    for (int i = 4; i < PoolSize; i++) pool[i] = $urandom;

    // random walk: segments lean towards insert or delete so the list swings
    // between empty and full; a small value pool keeps deletes hitting
    insert_pct = 50;
    burst      = 1'b0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
        burst = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 3) v = $urandom;
      else v = pool[$urandom_range(0, PoolSize - 1)];
      push_txn(($urandom_range(0, 99) < insert_pct) ? OpInsert : OpDelete, v,
               ($urandom_range(0, 39) == 0), burst ? 0 : $urandom_range(0, 9));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start || issued_cnt != seen_cnt) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0 && issued_cnt == seen_cnt) begin
      $display("== PASS ==");
    end else begin
      if (issued_cnt != seen_cnt)
        $display("%0t: %0d results never arrived", $time, issued_cnt - seen_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
